### rtl/erc_pkg.sv
// ----------------------------------------------------------------------------
// erc_pkg: shared types and constants of the eight-register core
// Opcodes, the decoded request carried from front to back, status and result.
// ----------------------------------------------------------------------------
package erc_pkg;

    localparam int MEM_BYTES_DEF = 262144;
    localparam int Q_DEPTH       = 2;
    localparam int NUM_REGS      = 8;
    localparam int REG_IDX_W     = 3;
    localparam int NUM_BANKS     = 4;
    localparam int BANK_W        = 2;
    localparam int WORD_BYTES    = 4;

    localparam logic [31:0] LOW_GUARD = 32'd4096;

    localparam logic [3:0] OPC_NOP   = 4'd0;
    localparam logic [3:0] OPC_MOVI  = 4'd1;
    localparam logic [3:0] OPC_ADD   = 4'd2;
    localparam logic [3:0] OPC_SUB   = 4'd3;
    localparam logic [3:0] OPC_XOR   = 4'd4;
    localparam logic [3:0] OPC_LOAD  = 4'd5;
    localparam logic [3:0] OPC_STORE = 4'd6;
    localparam logic [3:0] OPC_JMP   = 4'd7;
    localparam logic [3:0] OPC_JZ    = 4'd8;
    localparam logic [3:0] OPC_HALT  = 4'd9;

    typedef logic [REG_IDX_W-1:0] t_ridx;

    typedef struct packed {
        logic        restart;
        logic [3:0]  opcode;
        logic        blocked;
        t_ridx       ra;
        t_ridx       rb;
        logic [31:0] imm;
        t_ridx       peek;
    } t_uop;

    typedef struct packed {
        logic q_full;
        logic clearing;
    } t_front_stat;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        executed;
        logic        halted;
        logic        fault;
        logic [63:0] cycle_count;
        logic [31:0] peek_value;
    } t_result;

endpackage

### rtl/erc_front.sv
// ----------------------------------------------------------------------------
// erc_front: request intake and decode
// Accepts requests, folds unused opcodes to nop, checks the memory guard
// range and pushes a decoded request into the queue.
// ----------------------------------------------------------------------------
module erc_front import erc_pkg::*; #(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [3:0]  i_opcode,
    input  logic [7:0]  i_reg_a,
    input  logic [7:0]  i_reg_b,
    input  logic [31:0] i_imm,
    input  logic [2:0]  i_peek_index,
    input  t_front_stat i_stat,
    output logic        o_push,
    output t_uop        o_uop
);

    localparam logic [32:0] MemEnd = 33'(MEM_BYTES);

    logic [3:0]  op;
    logic [32:0] acc_end;

    // hold off while the queue is full or memory is still being cleared
    assign o_in_stall = i_stat.q_full || i_stat.clearing;
    assign o_push     = i_in_valid && !o_in_stall;

    assign op      = (i_opcode > OPC_HALT) ? OPC_NOP : i_opcode;
    assign acc_end = {1'b0, i_imm} + 33'(WORD_BYTES);

    always_comb begin
        o_uop.restart = i_kind;
        o_uop.opcode  = op;
        o_uop.blocked = (acc_end > MemEnd) || (i_imm < LOW_GUARD);
        o_uop.ra      = i_reg_a[REG_IDX_W-1:0];
        o_uop.rb      = i_reg_b[REG_IDX_W-1:0];
        o_uop.imm     = i_imm;
        o_uop.peek    = i_peek_index;
    end

endmodule

### rtl/erc_queue.sv
// ----------------------------------------------------------------------------
// erc_queue: decoded request queue
// Small FIFO between decode and execute so each side can stall on its own.
// ----------------------------------------------------------------------------
module erc_queue import erc_pkg::*; #(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_uop i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_uop o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_uop          r_ent [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wp;
    logic [PW-1:0] n_rp;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_ent[r_rp];

    assign n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_data;
        end
    end

endmodule

### rtl/erc_back.sv
// ----------------------------------------------------------------------------
// erc_back: execute unit
// Holds registers, pc, count, halt flag and the banked data memory; runs
// one decoded request at a time and fills the result register.
// ----------------------------------------------------------------------------
module erc_back import erc_pkg::*; #(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_q_valid,
    input  t_uop        i_q_uop,
    output logic        o_q_pop,
    output logic        o_clearing,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_res
);

    localparam int ROWS = (MEM_BYTES + NUM_BANKS - 1) / NUM_BANKS;
    localparam int RW   = $clog2(ROWS);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_LOAD  = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [RW-1:0]     r_clr_row;
    logic [31:0]       r_regs [NUM_REGS];
    logic [31:0]       r_pc;
    logic [31:0]       n_pc;
    logic [63:0]       r_count;
    logic [63:0]       n_count;
    logic              r_halt;
    logic              n_halt;
    logic [31:0]       r_plen;
    t_ridx             r_ld_ra;
    t_ridx             r_ld_peek;
    logic [BANK_W-1:0] r_ld_a0;
    logic              r_out_valid;
    t_result           r_res;
    t_result           n_res;
    logic [7:0]        r_mem [NUM_BANKS][ROWS];
    logic [7:0]        r_rd [NUM_BANKS];

    t_uop              u;
    logic              out_free;
    logic              pop;
    logic              produce;
    logic [31:0]       rav;
    logic [31:0]       rbv;
    logic              exec;
    logic              flt;
    logic              ld_issue;
    logic              st_issue;
    logic              rf_we;
    logic              rf_clr;
    t_ridx             rf_wa;
    logic [31:0]       rf_wd;
    t_ridx             pidx;
    logic [31:0]       peek_val;
    logic [31:0]       ld_word;
    logic [BANK_W-1:0] a0;
    logic [RW-1:0]     row_a;
    logic [RW-1:0]     acc_row [NUM_BANKS];
    logic [BANK_W-1:0] st_lane [NUM_BANKS];
    logic              mem_we;
    logic [RW-1:0]     wrow [NUM_BANKS];
    logic [7:0]        wdata [NUM_BANKS];

    assign u        = i_q_uop;
    assign out_free = !r_out_valid || !i_out_stall;
    assign pop      = (r_state == ST_RUN) && i_q_valid && out_free;
    assign rav      = r_regs[u.ra];
    assign rbv      = r_regs[u.rb];

    // bank k holds bytes whose address is k mod 4; an unaligned word spills
    // into the next row for the banks below the start lane
    assign a0    = u.imm[BANK_W-1:0];
    assign row_a = u.imm[RW+BANK_W-1:BANK_W];

    always_comb begin
        for (int k = 0; k < NUM_BANKS; k++) begin
            acc_row[k] = row_a + {{(RW-1){1'b0}}, (BANK_W'(k) < a0)};
            st_lane[k] = BANK_W'(k) - a0;
        end
    end

    always_comb begin
        for (int j = 0; j < NUM_BANKS; j++) begin
            ld_word[8*j +: 8] = r_rd[r_ld_a0 + BANK_W'(j)];
        end
    end

    always_comb begin
        n_pc     = r_pc;
        n_count  = r_count;
        n_halt   = r_halt;
        rf_we    = 1'b0;
        rf_clr   = 1'b0;
        rf_wa    = u.ra;
        rf_wd    = '0;
        exec     = 1'b0;
        flt      = 1'b0;
        ld_issue = 1'b0;
        st_issue = 1'b0;
        if (pop) begin
            if (u.restart) begin
                rf_clr  = 1'b1;
                n_pc    = '0;
                n_count = '0;
                n_halt  = 1'b0;
            end else if (r_halt || (r_pc >= r_plen)) begin
                n_halt = 1'b1;
            end else begin
                n_pc = r_pc + 32'd1;
                unique case (u.opcode)
                    OPC_MOVI: begin
                        rf_we = 1'b1;
                        rf_wd = u.imm;
                    end
                    OPC_ADD: begin
                        rf_we = 1'b1;
                        rf_wd = rav + rbv;
                    end
                    OPC_SUB: begin
                        rf_we = 1'b1;
                        rf_wd = rav - rbv;
                    end
                    OPC_XOR: begin
                        rf_we = 1'b1;
                        rf_wd = rav ^ rbv;
                    end
                    OPC_LOAD: begin
                        flt      = u.blocked;
                        ld_issue = !u.blocked;
                    end
                    OPC_STORE: begin
                        flt      = u.blocked;
                        st_issue = !u.blocked;
                    end
                    OPC_JMP: n_pc = u.imm;
                    OPC_JZ: begin
                        if (rav == '0) begin
                            n_pc = u.imm;
                        end
                    end
                    OPC_HALT: n_halt = 1'b1;
                    default: ;
                endcase
                if (flt) begin
                    n_halt = 1'b1;
                end else begin
                    exec    = 1'b1;
                    n_count = r_count + 64'd1;
                end
            end
        end else if ((r_state == ST_LOAD) && out_free) begin
            // write back the word held in the bank read register
            rf_we = 1'b1;
            rf_wa = r_ld_ra;
            rf_wd = ld_word;
        end
    end

    assign pidx    = (r_state == ST_LOAD) ? r_ld_peek : u.peek;
    assign produce = (pop && !ld_issue) || ((r_state == ST_LOAD) && out_free);

    always_comb begin
        if (rf_clr) begin
            peek_val = '0;
        end else if (rf_we && (rf_wa == pidx)) begin
            peek_val = rf_wd;
        end else begin
            peek_val = r_regs[pidx];
        end
    end

    always_comb begin
        n_res.next_pc     = n_pc;
        n_res.executed    = pop ? exec : 1'b1;
        n_res.halted      = n_halt;
        n_res.fault       = flt;
        n_res.cycle_count = n_count;
        n_res.peek_value  = peek_val;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_row == RW'(ROWS - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (ld_issue) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // memory write port: clearing sweep or store
    assign mem_we = (r_state == ST_CLEAR) || st_issue;

    always_comb begin
        for (int k = 0; k < NUM_BANKS; k++) begin
            if (r_state == ST_CLEAR) begin
                wrow[k]  = r_clr_row;
                wdata[k] = '0;
            end else begin
                wrow[k]  = acc_row[k];
                wdata[k] = rav[{st_lane[k], 3'b000} +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_BANKS; k++) begin
            if (mem_we) begin
                r_mem[k][wrow[k]] <= wdata[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_BANKS; k++) begin
            if (ld_issue) begin
                r_rd[k] <= r_mem[k][acc_row[k]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_row   <= '0;
            r_pc        <= '0;
            r_count     <= '0;
            r_halt      <= 1'b0;
            r_plen      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_count <= n_count;
            r_halt  <= n_halt;
            if (r_state == ST_CLEAR) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
            if (i_cfg_we) begin
                r_plen <= i_cfg_wdata;
            end
            if (rf_clr) begin
                for (int i = 0; i < NUM_REGS; i++) begin
                    r_regs[i] <= '0;
                end
            end else if (rf_we) begin
                r_regs[rf_wa] <= rf_wd;
            end
            if (out_free) begin
                r_out_valid <= produce;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_issue) begin
            r_ld_ra   <= u.ra;
            r_ld_peek <= u.peek;
            r_ld_a0   <= a0;
        end
        if (produce) begin
            r_res <= n_res;
        end
    end

    assign o_q_pop     = pop;
    assign o_clearing  = (r_state == ST_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    a_clear_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !pop)
        else $error("request popped during memory clear");

    a_restart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && u.restart) |=> ((r_pc == '0) && (r_count == '0) && !r_halt))
        else $error("restart did not clear core state");

    a_load_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_issue |=> (r_state == ST_LOAD))
        else $error("load issued without write-back cycle");

    a_fault_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.fault) |-> (r_res.halted && !r_res.executed))
        else $error("fault result not halted or marked executed");

endmodule

### rtl/eight_register_cpu_core_top.sv
// ----------------------------------------------------------------------------
// eight_register_cpu_core_top: small eight-register processor core
// Decode front, request queue and execute back with banked data memory.
//
// Input channel (i_in_valid / o_in_stall) carries one request: a restart or
// an instruction fetched by the environment at the last reported pc. Output
// channel (o_out_valid / i_out_stall) returns one result per request, in
// order. i_cfg_we writes program_length from i_cfg_wdata.
// An accepted request is popped from the two-entry queue once the back runs
// and the output is free; its result is registered at the pop, while a load
// first does a registered read of the four byte banks. Sustained rate is one
// request per cycle unless the output stalls or a load is in write-back.
// Reset is synchronous, active low: it clears core state and program_length,
// then sweeps the data memory to zero one row of four bytes per cycle, over
// ceil(MEM_BYTES/4) rows (65536 at the default), with o_in_stall high.
// A stalled result holds; the back stops popping, the queue fills and
// o_in_stall rises once both entries are taken.
// ----------------------------------------------------------------------------
module eight_register_cpu_core_top import erc_pkg::*; #(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [3:0]  i_opcode,
    input  logic [7:0]  i_reg_a,
    input  logic [7:0]  i_reg_b,
    input  logic [31:0] i_imm,
    input  logic [2:0]  i_peek_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_next_pc,
    output logic        o_executed,
    output logic        o_halted,
    output logic        o_fault,
    output logic [63:0] o_cycle_count,
    output logic [31:0] o_peek_value
);

    t_front_stat stat;
    logic        push;
    t_uop        push_uop;
    logic        q_full;
    logic        q_valid;
    t_uop        q_uop;
    logic        q_pop;
    logic        clearing;
    t_result     res;

    assign stat.q_full   = q_full;
    assign stat.clearing = clearing;

    erc_front #(
        .MEM_BYTES (MEM_BYTES)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_opcode     (i_opcode),
        .i_reg_a      (i_reg_a),
        .i_reg_b      (i_reg_b),
        .i_imm        (i_imm),
        .i_peek_index (i_peek_index),
        .i_stat       (stat),
        .o_push       (push),
        .o_uop        (push_uop)
    );

    erc_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_uop),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_uop)
    );

    erc_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_uop     (q_uop),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res)
    );

    assign o_next_pc     = res.next_pc;
    assign o_executed    = res.executed;
    assign o_halted      = res.halted;
    assign o_fault       = res.fault;
    assign o_cycle_count = res.cycle_count;
    assign o_peek_value  = res.peek_value;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: request/result check of the eight-register core
// Requests go in from a table of directed steps and then in random phases,
// each phase under its own program length. An in-bench copy of the core's
// registers, pc, count, halt flag and byte memory works out every result,
// and each returned result is compared field by field with the oldest one due.
// ----------------------------------------------------------------------------
module testbench;
    import erc_pkg::*;

    localparam logic        KIND_EXEC    = 1'b0;
    localparam logic        KIND_RESTART = 1'b1;
    localparam logic [3:0]  OPC_SPARE_LO = 4'd10;
    localparam logic [3:0]  OPC_SPARE_HI = 4'd15;
    localparam int unsigned MEM_TOP      = MEM_BYTES_DEF;
    localparam int          QUIET_LIMIT  = 300000;
    localparam int          PHASE_ITEMS  = 400;
    localparam int          NUM_PHASES   = 5;

    typedef struct packed {
        logic        kind;
        logic [3:0]  opcode;
        logic [7:0]  reg_a;
        logic [7:0]  reg_b;
        logic [31:0] imm;
        logic [2:0]  peek;
    } t_core_req;

    typedef struct {
        bit          relen;
        logic [31:0] len;
        t_core_req   req;
        bit          typed;
        t_result     want;
    } t_step_row;

    localparam t_result CLEARED = '0;
    localparam t_result FAULTED = '{32'd1, 1'b0, 1'b1, 1'b1, 64'd0, 32'd0};

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [31:0] i_cfg_wdata  = '0;
    logic        i_in_valid   = 1'b0;
    logic        i_kind       = 1'b0;
    logic [3:0]  i_opcode     = '0;
    logic [7:0]  i_reg_a      = '0;
    logic [7:0]  i_reg_b      = '0;
    logic [31:0] i_imm        = '0;
    logic [2:0]  i_peek_index = '0;
    logic        i_out_stall  = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_next_pc;
    logic        o_executed;
    logic        o_halted;
    logic        o_fault;
    logic [63:0] o_cycle_count;
    logic [31:0] o_peek_value;

    // in-bench core state
    logic [31:0] core_regs [NUM_REGS];
    logic [31:0] core_pc;
    logic [63:0] core_count;
    logic        core_halted;
    logic [31:0] prog_len;
    bit   [7:0]  data_bytes [MEM_BYTES_DEF];

    t_result     results_due [$];
    int          mismatch_count = 0;
    bit          calm           = 1'b0;
    bit          gaps_on        = 1'b1;
    int unsigned sink_left      = 0;
    bit          sink_hold      = 1'b0;
    int unsigned quiet_cycles   = 0;

    t_step_row directed_steps [26] = '{
        '{1'b1, 32'd0,
          '{KIND_EXEC, OPC_MOVI, 8'h00, 8'h00, 32'hDEAD_BEEF, 3'd0},
          1'b1, '{32'd0, 1'b0, 1'b1, 1'b0, 64'd0, 32'd0}},
        '{1'b1, 32'hFFFF_FFFF,
          '{KIND_RESTART, OPC_NOP, 8'h00, 8'h00, 32'h0, 3'd0}, 1'b1, CLEARED},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_MOVI, 8'hFF, 8'h00, 32'hFFFF_FFFF, 3'd7},
          1'b1, '{32'd1, 1'b1, 1'b0, 1'b0, 64'd1, 32'hFFFF_FFFF}},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_MOVI, 8'h08, 8'h00, 32'd1, 3'd0},
          1'b1, '{32'd2, 1'b1, 1'b0, 1'b0, 64'd2, 32'd1}},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_ADD, 8'h00, 8'hF7, 32'h5A5A_A5A5, 3'd0}, 1'b0, CLEARED},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_SUB, 8'h01, 8'h07, 32'h0, 3'd1}, 1'b0, CLEARED},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_XOR, 8'h02, 8'h07, 32'h0, 3'd2}, 1'b0, CLEARED},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_STORE, 8'h07, 8'h00, LOW_GUARD, 3'd7}, 1'b0, CLEARED},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_LOAD, 8'h03, 8'h00, LOW_GUARD, 3'd3}, 1'b0, CLEARED},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_STORE, 8'h01, 8'h00, 32'(MEM_TOP - 4), 3'd1}, 1'b0, CLEARED},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_LOAD, 8'h04, 8'h00, 32'(MEM_TOP - 4), 3'd4}, 1'b0, CLEARED},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_LOAD, 8'h05, 8'h00, LOW_GUARD + 32'd2, 3'd5}, 1'b0, CLEARED},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_JZ, 8'h00, 8'h00, 32'd20, 3'd0}, 1'b0, CLEARED},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_JZ, 8'h07, 8'h00, 32'd3, 3'd7}, 1'b0, CLEARED},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_JMP, 8'h00, 8'h00, 32'hFFFF_FFFF, 3'd6}, 1'b0, CLEARED},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_NOP, 8'h00, 8'h00, 32'h0, 3'd7}, 1'b0, CLEARED},
        '{1'b0, 32'd0,
          '{KIND_RESTART, OPC_HALT, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 3'd7}, 1'b1, CLEARED},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_LOAD, 8'h80, 8'h00, LOW_GUARD - 32'd1, 3'd0}, 1'b1, FAULTED},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_SPARE_HI, 8'h00, 8'h00, 32'h0, 3'd7},
          1'b1, '{32'd1, 1'b0, 1'b1, 1'b0, 64'd0, 32'd0}},
        '{1'b0, 32'd0,
          '{KIND_RESTART, OPC_NOP, 8'h00, 8'h00, 32'h0, 3'd0}, 1'b1, CLEARED},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_STORE, 8'hFF, 8'h00, 32'(MEM_TOP - 3), 3'd0}, 1'b1, FAULTED},
        '{1'b0, 32'd0,
          '{KIND_RESTART, OPC_NOP, 8'h00, 8'h00, 32'h0, 3'd0}, 1'b1, CLEARED},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_SPARE_LO, 8'h00, 8'h00, 32'h0, 3'd7},
          1'b1, '{32'd1, 1'b1, 1'b0, 1'b0, 64'd1, 32'd0}},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_HALT, 8'h00, 8'h00, 32'h0, 3'd2},
          1'b1, '{32'd2, 1'b1, 1'b1, 1'b0, 64'd2, 32'd0}},
        '{1'b0, 32'd0,
          '{KIND_RESTART, OPC_NOP, 8'h00, 8'h00, 32'h0, 3'd0}, 1'b1, CLEARED},
        '{1'b0, 32'd0,
          '{KIND_EXEC, OPC_LOAD, 8'hFF, 8'h00, 32'hFFFF_FFFF, 3'd0}, 1'b1, FAULTED}
    };

    eight_register_cpu_core_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_opcode     (i_opcode),
        .i_reg_a      (i_reg_a),
        .i_reg_b      (i_reg_b),
        .i_imm        (i_imm),
        .i_peek_index (i_peek_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_next_pc    (o_next_pc),
        .o_executed   (o_executed),
        .o_halted     (o_halted),
        .o_fault      (o_fault),
        .o_cycle_count(o_cycle_count),
        .o_peek_value (o_peek_value)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit addr_blocked(logic [31:0] addr);
        return (64'(addr) + 64'(WORD_BYTES)) > 64'(MEM_TOP) || addr < LOW_GUARD;
    endfunction

    function automatic void clear_core();
        foreach (core_regs[i]) core_regs[i] = '0;
        core_pc     = '0;
        core_count  = '0;
        core_halted = 1'b0;
    endfunction

    // Advance the in-bench core by one request and return the result it gives.
    function automatic t_result execute_step(t_core_req r);
        t_result    res;
        logic [2:0] ra;
        logic [2:0] rb;
        bit         fault;
        res   = '0;
        ra    = r.reg_a[2:0];
        rb    = r.reg_b[2:0];
        fault = 1'b0;
        if (r.kind == KIND_RESTART) begin
            clear_core();
        end else if (core_halted || core_pc >= prog_len) begin
            core_halted = 1'b1;
        end else begin
            core_pc = core_pc + 32'd1;
            case (r.opcode)
                OPC_MOVI: core_regs[ra] = r.imm;
                OPC_ADD:  core_regs[ra] = core_regs[ra] + core_regs[rb];
                OPC_SUB:  core_regs[ra] = core_regs[ra] - core_regs[rb];
                OPC_XOR:  core_regs[ra] = core_regs[ra] ^ core_regs[rb];
                OPC_LOAD: begin
                    if (addr_blocked(r.imm)) begin
                        fault = 1'b1;
                    end else begin
                        for (int k = 0; k < WORD_BYTES; k++)
                            core_regs[ra][8*k +: 8] = data_bytes[r.imm + k];
                    end
                end
                OPC_STORE: begin
                    if (addr_blocked(r.imm)) begin
                        fault = 1'b1;
                    end else begin
                        for (int k = 0; k < WORD_BYTES; k++)
                            data_bytes[r.imm + k] = core_regs[ra][8*k +: 8];
                    end
                end
                OPC_JMP:  core_pc = r.imm;
                OPC_JZ:   if (core_regs[ra] == '0) core_pc = r.imm;
                OPC_HALT: core_halted = 1'b1;
                default:  ;
            endcase
            if (fault) begin
                core_halted = 1'b1;
            end else begin
                res.executed = 1'b1;
                core_count   = core_count + 64'd1;
            end
        end
        res.next_pc     = core_pc;
        res.halted      = core_halted;
        res.fault       = fault;
        res.cycle_count = core_count;
        res.peek_value  = core_regs[r.peek];
        return res;
    endfunction

    function automatic logic [31:0] data_address();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) return LOW_GUARD + $urandom_range(0, 60);
        if (pick < 82) return MEM_TOP - 4 - $urandom_range(0, 60);
        if (pick < 88) return $urandom_range(0, LOW_GUARD - 1);
        if (pick < 94) return MEM_TOP - $urandom_range(1, 3);
        return $urandom;
    endfunction

    function automatic logic [31:0] jump_target();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, 63);
    endfunction

    // Mostly live programs: restart soon after the core stops.
    function automatic t_core_req random_request();
        t_core_req   r;
        int unsigned pick;
        r.kind   = KIND_EXEC;
        r.opcode = OPC_NOP;
        r.reg_a  = 8'($urandom);
        r.reg_b  = 8'($urandom);
        r.imm    = $urandom;
        r.peek   = 3'($urandom);
        pick     = $urandom_range(0, 99);
        if (((core_halted || core_pc >= prog_len) && pick < 85) || pick == 99) begin
            r.kind   = KIND_RESTART;
            r.opcode = 4'($urandom);
            return r;
        end
        pick = $urandom_range(0, 99);
        if (pick < 16) begin
            r.opcode = OPC_MOVI;
            if ($urandom_range(0, 3) == 0) r.imm = '0;
        end else if (pick < 40) begin
            r.opcode = OPC_ADD + 4'($urandom_range(0, 2));
        end else if (pick < 56) begin
            r.opcode = OPC_STORE;
            r.imm    = data_address();
        end else if (pick < 74) begin
            r.opcode = OPC_LOAD;
            r.imm    = data_address();
        end else if (pick < 84) begin
            r.opcode = OPC_JZ;
            r.imm    = jump_target();
        end else if (pick < 89) begin
            r.opcode = OPC_JMP;
            r.imm    = jump_target();
        end else if (pick < 91) begin
            r.opcode = OPC_HALT;
        end else if ($urandom_range(0, 1) == 0) begin
            r.opcode = OPC_NOP;
        end else begin
            r.opcode = 4'($urandom_range(OPC_SPARE_LO, OPC_SPARE_HI));
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Present one request, hold it until taken, then record its result.
    task automatic issue(input t_core_req r, input bit typed, input t_result want);
        t_result res;
        i_in_valid   <= 1'b1;
        i_kind       <= r.kind;
        i_opcode     <= r.opcode;
        i_reg_a      <= r.reg_a;
        i_reg_b      <= r.reg_b;
        i_imm        <= r.imm;
        i_peek_index <= r.peek;
        do @(posedge i_clk); while (o_in_stall);
        res = execute_step(r);
        results_due.insert(results_due.size(), typed ? want : res);
    endtask

    task automatic maybe_gap();
        if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Drain all results, then write the register while the core is idle.
    task automatic set_program_length(input logic [31:0] len);
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        prog_len     = len;
    endtask

    // the sink draws at random whether to hold i_out_stall and for how long
    always @(posedge i_clk) begin
        if (calm) begin
            i_out_stall <= 1'b0;
        end else if (sink_left == 0) begin
            sink_hold    = ($urandom_range(0, 2) == 0);
            sink_left    = sink_hold ? $urandom_range(0, 15) : $urandom_range(1, 40);
            i_out_stall <= sink_hold;
        end else begin
            sink_left--;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                flag_mismatch("result with none due");
            end else begin
                want = results_due.pop_front();
                check_field("next_pc", 64'(o_next_pc), 64'(want.next_pc));
                check_field("executed", 64'(o_executed), 64'(want.executed));
                check_field("halted", 64'(o_halted), 64'(want.halted));
                check_field("fault", 64'(o_fault), 64'(want.fault));
                check_field("cycle_count", o_cycle_count, want.cycle_count);
                check_field("peek_value", 64'(o_peek_value), 64'(want.peek_value));
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        logic [31:0] phase_lengths [NUM_PHASES];
        phase_lengths = '{32'd64, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd20};
        phase_lengths[2] = $urandom;
        clear_core();
        prog_len = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[i]) begin
            if (directed_steps[i].relen) set_program_length(directed_steps[i].len);
            maybe_gap();
            issue(directed_steps[i].req, directed_steps[i].typed, directed_steps[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_program_length(phase_lengths[p]);
            if (p == NUM_PHASES - 1) calm = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0) gaps_on = ($urandom_range(0, 1) == 1);
                maybe_gap();
                issue(random_request(), 1'b0, CLEARED);
            end
        end

        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
